FILE: src/wmmcd_pkg.sv
// ----------------------------------------------------------------------------
// wmmcd_pkg: shared types and constants of the min/max column decimator
// Widths, register indexes and the item that passes from front to back.
// ----------------------------------------------------------------------------
package wmmcd_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W       = 13;
    localparam int Y_W         = 22;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] CFG_SAMPLES_PER_PIXEL = 8'd0;
    localparam logic [7:0] CFG_VERTICAL_ZOOM     = 8'd1;
    localparam logic [7:0] CFG_VIEW_HEIGHT       = 8'd2;
    localparam logic [7:0] CFG_COLUMN_COUNT      = 8'd3;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    typedef logic signed [Y_W-1:0] y_t;

    typedef struct packed {
        logic [11:0]        column;
        logic signed [15:0] min_v;
        logic signed [15:0] max_v;
        logic               last;
    } column_item_t;

endpackage

FILE: src/waveform_min_max_column_decimator.sv
// ----------------------------------------------------------------------------
// waveform_min_max_column_decimator: min/max peak decimation for a waveform view
// Reduces a stream of audio samples to one drawing result per pixel column.
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream, one item per cycle while s_tready is high, with
// s_tlast on the final sample of a frame. Each column that closes gives one item
// on the m_ stream; m_tlast marks the item caused by the final sample. Samples
// beyond the last column give no item. The configuration channel writes the four
// registers by index and is always ready; the user must make writes only while
// the block is idle, as the block itself does not enforce it. Throughput is one
// sample per cycle while s_tready is high. A closing sample is written into the
// column queue at the edge that accepts it; its result then passes through the
// multiply, multiply and scale stages of the mappers and the output register
// before it is valid on m_. When the receiver stalls, the result pipeline holds
// and the four-entry queue fills; s_tready falls only when that queue is full.
// Reset clears the frame state and loads the register defaults: one sample
// per column, zoom 1.0, height 256 and 1024 columns.
// ----------------------------------------------------------------------------
module waveform_min_max_column_decimator
    import wmmcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // sample[15:0]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // column, mid_y, prev_y, top_y, bottom_y, zeros
    output logic [2:0]   m_tuser,   // draw_connector, draw_column, is_point
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [31:0]      spp_reg;
    logic [15:0]      zoom_reg;
    logic [12:0]      height_reg;
    logic [12:0]      count_reg;

    logic [31:0]      eff_spp;
    logic [12:0]      eff_height;
    logic [COL_W-1:0] eff_count;

    logic             q_full, q_not_empty, q_pop, push;
    column_item_t     push_item, head;
    logic             accept;

    logic [11:0]      column;
    y_t               mid_y, prev_y, top_y, bottom_y;
    logic             draw_connector, draw_column, is_point;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg    <= 32'd65536;
            zoom_reg   <= 16'd256;
            height_reg <= 13'd256;
            count_reg  <= 13'd1024;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SAMPLES_PER_PIXEL: spp_reg    <= cfg_data;
                CFG_VERTICAL_ZOOM:     zoom_reg   <= cfg_data[15:0];
                CFG_VIEW_HEIGHT:       height_reg <= cfg_data[12:0];
                CFG_COLUMN_COUNT:      count_reg  <= cfg_data[12:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        eff_spp    = (spp_reg < 32'd65536) ? 32'd65536 : spp_reg;
        eff_height = (height_reg == 13'd0) ? 13'd1 : height_reg;
        if (count_reg == 13'd0)
        begin
            eff_count = COL_W'(1);
        end
        else if (count_reg > COL_W'(MAX_COLUMNS))
        begin
            eff_count = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            eff_count = count_reg;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    wmmcd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    ($signed(s_tdata)),
        .last      (s_tlast),
        .eff_spp   (eff_spp),
        .eff_count (eff_count),
        .push      (push),
        .item      (push_item)
    );

    wmmcd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    wmmcd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_not_empty),
        .in_item        (head),
        .pop            (q_pop),
        .zoom           (zoom_reg),
        .height         (eff_height),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .column         (column),
        .mid_y          (mid_y),
        .prev_y         (prev_y),
        .draw_connector (draw_connector),
        .top_y          (top_y),
        .bottom_y       (bottom_y),
        .draw_column    (draw_column),
        .is_point       (is_point),
        .frame_end      (m_tlast)
    );

    assign m_tdata = {4'd0, bottom_y, top_y, prev_y, mid_y, column};
    assign m_tuser = {is_point, draw_column, draw_connector};

endmodule

FILE: src/wmmcd_front.sv
// ----------------------------------------------------------------------------
// wmmcd_front: sample intake and column tracking
// Keeps the running minimum and maximum and emits one item per closed column.
// ----------------------------------------------------------------------------
module wmmcd_front
    import wmmcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [15:0] sample,
    input  logic               last,
    input  logic [31:0]        eff_spp,
    input  logic [COL_W-1:0]   eff_count,
    output logic               push,
    output column_item_t       item
);

    logic [COL_W-1:0]   col_idx_reg, col_idx_next;
    logic [31:0]        smp_idx_reg, smp_idx_next;
    logic [47:0]        bound_reg, bound_next;
    logic signed [15:0] min_reg, min_next;
    logic signed [15:0] max_reg, max_next;
    logic               done_reg, done_next;

    logic               exhausted;
    logic [47:0]        bnd;
    logic signed [15:0] nmin, nmax;
    logic [31:0]        si1;
    logic [COL_W-1:0]   ci1;
    logic               close;

    always_comb
    begin
        exhausted = done_reg || (col_idx_reg >= eff_count);
        bnd  = (smp_idx_reg == 32'd0 && col_idx_reg == '0) ? {16'd0, eff_spp} : bound_reg;
        nmin = (sample < min_reg) ? sample : min_reg;
        nmax = (sample > max_reg) ? sample : max_reg;
        si1  = smp_idx_reg + 32'd1;
        ci1  = col_idx_reg + 1'b1;
        close = last || !(si1 < bnd[47:16]);

        col_idx_next = col_idx_reg;
        smp_idx_next = smp_idx_reg;
        bound_next   = bound_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        done_next    = done_reg;
        push         = 1'b0;
        item.column  = col_idx_reg[11:0];
        item.min_v   = nmin;
        item.max_v   = nmax;
        item.last    = last;

        if (accept)
        begin
            if (exhausted)
            begin
                done_next = 1'b1;
            end
            else if (!close)
            begin
                min_next     = nmin;
                max_next     = nmax;
                smp_idx_next = si1;
                bound_next   = bnd;
            end
            else
            begin
                push         = 1'b1;
                min_next     = SAMPLE_MAX;
                max_next     = SAMPLE_MIN;
                smp_idx_next = si1;
                col_idx_next = ci1;
                bound_next   = bnd + {16'd0, eff_spp};
                done_next    = (ci1 >= eff_count);
            end
            if (last)
            begin
                col_idx_next = '0;
                smp_idx_next = 32'd0;
                bound_next   = {16'd0, eff_spp};
                min_next     = SAMPLE_MAX;
                max_next     = SAMPLE_MIN;
                done_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg <= '0;
            smp_idx_reg <= 32'd0;
            bound_reg   <= 48'd65536;
            min_reg     <= SAMPLE_MAX;
            max_reg     <= SAMPLE_MIN;
            done_reg    <= 1'b0;
        end
        else
        begin
            col_idx_reg <= col_idx_next;
            smp_idx_reg <= smp_idx_next;
            bound_reg   <= bound_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            done_reg    <= done_next;
        end
    end

endmodule

FILE: src/wmmcd_queue.sv
// ----------------------------------------------------------------------------
// wmmcd_queue: short queue between front and back
// Holds closed-column items so that intake and mapping stall separately.
// ----------------------------------------------------------------------------
module wmmcd_queue
    import wmmcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  column_item_t push_item,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output column_item_t head
);

    column_item_t         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_reg, rd_reg;
    logic [QUEUE_AW:0]    cnt_reg;
    logic                 do_push, do_pop;

    assign full      = (cnt_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/wmmcd_map.sv
// ----------------------------------------------------------------------------
// wmmcd_map: three-stage screen y mapping
// y = trunc(H/2 - v*Z*H/2^24) from twice the value, saturated to 22 bits.
// ----------------------------------------------------------------------------
module wmmcd_map
    import wmmcd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [16:0] twice_v,
    input  logic [15:0]        zoom,
    input  logic [12:0]        height,
    output y_t                 y
);

    logic signed [33:0] p1_reg;
    logic signed [47:0] p2_reg;
    y_t                 y_reg;
    logic signed [48:0] num;
    logic signed [48:0] adj;
    logic signed [48:0] q;
    y_t                 y_next;

    always_comb
    begin
        num = $signed({11'd0, height, 25'd0}) >>> 1;
        num = num - 49'(p2_reg);
        adj = num + (num[48] ? 49'sd33554431 : 49'sd0);
        q   = adj >>> 25;
        if (q > 49'(Y_MAX))
        begin
            y_next = Y_MAX;
        end
        else if (q < 49'(Y_MIN))
        begin
            y_next = Y_MIN;
        end
        else
        begin
            y_next = q[Y_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= 34'(twice_v * $signed({1'b0, zoom}));
            p2_reg <= 48'(p1_reg * $signed({1'b0, height}));
            y_reg  <= y_next;
        end
    end

    assign y = y_reg;

endmodule

FILE: src/wmmcd_back.sv
// ----------------------------------------------------------------------------
// wmmcd_back: column result pipeline
// Maps min, max and mid to screen y, derives the draw flags, holds the result.
// ----------------------------------------------------------------------------
module wmmcd_back
    import wmmcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  column_item_t in_item,
    output logic         pop,
    input  logic [15:0]  zoom,
    input  logic [12:0]  height,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [11:0]  column,
    output y_t           mid_y,
    output y_t           prev_y,
    output logic         draw_connector,
    output y_t           top_y,
    output y_t           bottom_y,
    output logic         draw_column,
    output logic         is_point,
    output logic         frame_end
);

    logic        en;
    logic        v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic [11:0] col1_reg, col2_reg, col3_reg;
    logic        last1_reg, last2_reg, last3_reg;
    y_t          prev_reg;
    logic        have_prev;
    y_t          prev_use;
    y_t          mid_w, top_w, bot_w;
    logic signed [Y_W:0] h_s;
    logic        conn, colf, pt;

    logic [11:0] column_reg;
    y_t          mid_reg, prevo_reg, top_reg, bot_reg;
    logic        conn_reg, colf_reg, pt_reg, last_reg;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && in_valid;

    wmmcd_map u_mid
    (
        .clk     (clk),
        .en      (en),
        .twice_v (17'(in_item.min_v) + 17'(in_item.max_v)),
        .zoom    (zoom),
        .height  (height),
        .y       (mid_w)
    );

    wmmcd_map u_top
    (
        .clk     (clk),
        .en      (en),
        .twice_v ({in_item.max_v, 1'b0}),
        .zoom    (zoom),
        .height  (height),
        .y       (top_w)
    );

    wmmcd_map u_bot
    (
        .clk     (clk),
        .en      (en),
        .twice_v ({in_item.min_v, 1'b0}),
        .zoom    (zoom),
        .height  (height),
        .y       (bot_w)
    );

    // Column zero opens a frame, so it has no previous column.
    always_comb
    begin
        h_s       = $signed({10'd0, height});
        have_prev = (col3_reg != '0);
        prev_use  = have_prev ? prev_reg : '0;
        conn = have_prev && (!mid_w[Y_W-1] || !prev_use[Y_W-1])
            && ((23'(mid_w) < h_s) || (23'(prev_use) < h_s));
        colf = !((top_w[Y_W-1] && bot_w[Y_W-1])
            || ((23'(top_w) >= h_s) && (23'(bot_w) >= h_s)));
        pt   = colf && (top_w == bot_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col1_reg   <= in_item.column;
            last1_reg  <= in_item.last;
            col2_reg   <= col1_reg;
            last2_reg  <= last1_reg;
            col3_reg   <= col2_reg;
            last3_reg  <= last2_reg;
            column_reg <= col3_reg;
            mid_reg    <= mid_w;
            prevo_reg  <= prev_use;
            top_reg    <= top_w;
            bot_reg    <= bot_w;
            conn_reg   <= conn;
            colf_reg   <= colf;
            pt_reg     <= pt;
            last_reg   <= last3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
            if (v3_reg)
            begin
                prev_reg <= mid_w;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign column         = column_reg;
    assign mid_y          = mid_reg;
    assign prev_y         = prevo_reg;
    assign draw_connector = conn_reg;
    assign top_y          = top_reg;
    assign bottom_y       = bot_reg;
    assign draw_column    = colf_reg;
    assign is_point       = pt_reg;
    assign frame_end      = last_reg;

endmodule
